// File: sv/ow_pkg.sv
// ----------------------------------------------------------------------------
// ow_pkg
// Shared types, slot timing table and result layout for the 1-Wire master.
// ----------------------------------------------------------------------------
package ow_pkg;

    localparam int unsigned CntW = 11;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_WAIT = 3'd1,
        PH_RST_LOW  = 3'd2,
        PH_RST_REL  = 3'd3,
        PH_RST_REC  = 3'd4,
        PH_SLOT_LOW = 3'd5,
        PH_SLOT_REL = 3'd6,
        PH_SLOT_REC = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_RESET = 2'd1,
        REQ_BIT   = 2'd2,
        REQ_BYTE  = 2'd3
    } t_req;

    // One result word, as produced for every accepted tick
    typedef struct packed {
        logic       rejected;
        logic       presence;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } t_ow_result;

    localparam int unsigned ResW = $bits(t_ow_result);

    // Phase length in quarter-microsecond ticks; bit picks read vs write slot
    function automatic logic [CntW-1:0] phase_len(input t_phase ph, input logic bit_val,
                                                  input logic od);
        logic [CntW-1:0] len;
        begin
            len = CntW'(1);
            case (ph)
                PH_RST_WAIT: len = od ? CntW'(10)  : CntW'(0);
                PH_RST_LOW:  len = od ? CntW'(280) : CntW'(1920);
                PH_RST_REL:  len = od ? CntW'(34)  : CntW'(280);
                PH_RST_REC:  len = od ? CntW'(160) : CntW'(1640);
                PH_SLOT_LOW: begin
                    if (bit_val) len = od ? CntW'(6)  : CntW'(24);
                    else         len = od ? CntW'(30) : CntW'(240);
                end
                PH_SLOT_REL: begin
                    if (bit_val) len = od ? CntW'(3)  : CntW'(36);
                    else         len = od ? CntW'(10) : CntW'(40);
                end
                PH_SLOT_REC: len = od ? CntW'(28) : CntW'(220);
                default:     len = CntW'(1);
            endcase
            return len;
        end
    endfunction

endpackage

// File: sv/ow_step.sv
// ----------------------------------------------------------------------------
// ow_step
// Sequencer state and the per-tick update of the reset and time-slot engine.
// ----------------------------------------------------------------------------
module ow_step
    import ow_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic       i_overdrive,
    input  t_req       i_req,
    input  logic [7:0] i_send_data,
    input  logic       i_line_level,
    output t_ow_result o_result
);

    t_phase          r_phase,   n_phase;
    logic [CntW-1:0] r_cnt,     n_cnt;
    logic [3:0]      r_bits,    n_bits;
    logic [7:0]      r_send,    n_send;
    logic [7:0]      r_recv,    n_recv;
    logic            r_pres,    n_pres;
    logic            r_single,  n_single;

    logic            s_bit;
    logic            s_finished;
    logic            s_bit_end;
    logic            s_rst_rec;
    t_ow_result      s_res;

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_bits     = r_bits;
        n_send     = r_send;
        n_recv     = r_recv;
        n_pres     = r_pres;
        n_single   = r_single;
        s_res      = '0;
        s_bit      = 1'b0;
        s_finished = 1'b0;
        s_bit_end  = 1'b0;
        s_rst_rec  = 1'b0;

        // Start a command when idle, flag it otherwise
        if (r_phase != PH_IDLE) begin
            s_res.rejected = (i_req != REQ_TICK);
        end else if (i_req != REQ_TICK) begin
            n_cnt  = '0;
            n_recv = '0;
            if (i_req == REQ_RESET) begin
                n_phase  = (phase_len(PH_RST_WAIT, 1'b0, i_overdrive) == '0) ?
                           PH_RST_LOW : PH_RST_WAIT;
                n_bits   = '0;
                n_single = 1'b0;
            end else begin
                n_phase  = PH_SLOT_LOW;
                n_single = (i_req == REQ_BIT);
                n_send   = n_single ? {7'd0, i_send_data[0]} : i_send_data;
                n_bits   = n_single ? 4'd1 : 4'd8;
            end
        end

        if (n_phase != PH_IDLE) begin
            s_res.busy_res  = 1'b1;
            s_bit           = n_send[0];
            s_res.drive_low = (n_phase == PH_RST_LOW) || (n_phase == PH_SLOT_LOW);
            // Sample on the first tick of a recovery wait
            if (n_cnt == '0) begin
                if (n_phase == PH_RST_REC) begin
                    n_pres = ~i_line_level;
                end else if (n_phase == PH_SLOT_REC) begin
                    n_recv = {i_line_level, n_recv[7:1]};
                end
            end
            n_cnt = n_cnt + CntW'(1);
            if (n_cnt >= phase_len(n_phase, s_bit, i_overdrive)) begin
                n_cnt = '0;
                case (n_phase)
                    PH_RST_WAIT: n_phase = PH_RST_LOW;
                    PH_RST_LOW:  n_phase = PH_RST_REL;
                    PH_RST_REL:  n_phase = PH_RST_REC;
                    PH_RST_REC:  s_finished = 1'b1;
                    PH_SLOT_LOW: n_phase = PH_SLOT_REL;
                    PH_SLOT_REL: begin
                        if (s_bit) begin
                            n_phase = PH_SLOT_REC;
                        end else begin
                            // Write slot reads back a zero
                            n_recv    = {1'b0, n_recv[7:1]};
                            s_bit_end = 1'b1;
                        end
                    end
                    default:     s_bit_end = 1'b1;
                endcase
                if (s_bit_end) begin
                    n_send = {1'b0, n_send[7:1]};
                    if (n_bits <= 4'd1) begin
                        n_bits     = '0;
                        s_finished = 1'b1;
                    end else begin
                        n_bits  = n_bits - 4'd1;
                        n_phase = PH_SLOT_LOW;
                    end
                end
                if (s_finished) begin
                    s_rst_rec       = (n_phase == PH_RST_REC);
                    s_res.done_res  = 1'b1;
                    s_res.read_data = s_rst_rec ? 8'd0 :
                                      (n_single ? {7'd0, n_recv[7]} : n_recv);
                    n_phase         = PH_IDLE;
                end
            end
        end
        s_res.presence = n_pres;
    end

    assign o_result = s_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cnt    <= '0;
            r_bits   <= '0;
            r_send   <= '0;
            r_recv   <= '0;
            r_pres   <= 1'b0;
            r_single <= 1'b0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_bits   <= n_bits;
            r_send   <= n_send;
            r_recv   <= n_recv;
            r_pres   <= n_pres;
            r_single <= n_single;
        end
    end

    a_idle_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_cnt == '0))
        else $error("slot counter nonzero while idle");

    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= 4'd8)
        else $error("bit count out of range");

    a_single_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_single |-> (r_bits <= 4'd1))
        else $error("single-bit touch with more than one bit pending");

endmodule

// File: sv/onewire_bus_master.sv
// ----------------------------------------------------------------------------
// onewire_bus_master
// 1-Wire master: reset/presence and LSB-first read/write time slots.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one word per quarter-microsecond tick on the s_axis channel. tuser
//   carries the command (plain tick, reset, bit touch, byte touch); tdata
//   carries the byte to send and the sampled DQ level. Each accepted word
//   yields exactly one result word on m_axis: drive_low for that tick, busy,
//   done with read_data, the latest presence flag and a reject flag for a
//   command given while a sequence runs.
//   Throughput: one word per cycle while s_axis_tready is high; the state
//   update is a single add-and-compare pass on the slot counter. A two-entry
//   output (result register plus skid register) registers each result and
//   keeps s_axis_tready high until a stall of m_axis fills the skid entry,
//   then drops it until the receiver drains it. No word is lost or repeated.
//   The APB port holds the overdrive bit at address 0; write it only while
//   no sequence runs.
//   Reset (synchronous, active low) returns the engine to idle, clears the
//   shift registers, presence flag and overdrive, and empties the output.
// ----------------------------------------------------------------------------
module onewire_bus_master
    import ow_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,

    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [15:0]     s_axis_tdata,   // [7:0] send_data, [8] line_level, pad
    input  logic [1:0]      s_axis_tuser,   // [1:0] req_type

    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [15:0]     m_axis_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                            // [10:3] read_data, [11] presence,
                                            // [12] rejected, pad

    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam logic RegOverdrive = 1'b0;   // register index, paddr[2]

    logic       r_overdrive;
    logic       r_out_valid;
    t_ow_result r_out;
    logic       r_skid_valid;
    t_ow_result r_skid;

    logic       s_accept;
    logic       s_pop;
    t_ow_result s_result;

    // Config port: zero-wait APB, overdrive in bit 0
    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegOverdrive) ? {31'd0, r_overdrive} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overdrive <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == RegOverdrive)) begin
            r_overdrive <= pwdata[0];
        end
    end

    // Take a tick while the skid entry is free
    assign s_axis_tready = !r_skid_valid;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_pop         = r_out_valid && m_axis_tready;

    ow_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (s_accept),
        .i_overdrive  (r_overdrive),
        .i_req        (t_req'(s_axis_tuser)),
        .i_send_data  (s_axis_tdata[7:0]),
        .i_line_level (s_axis_tdata[8]),
        .o_result     (s_result)
    );

    // Result register with a skid entry behind it; the skid drains first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || s_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= s_accept;
            end else begin
                r_out_valid  <= s_accept;
            end
        end else if (s_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || s_pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (s_accept) r_skid <= s_result;
            end else if (s_accept) begin
                r_out <= s_result;
            end
        end else if (s_accept) begin
            r_skid <= s_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(16 - ResW)'(0), r_out};

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty result register");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> r_out.busy_res)
        else $error("done reported outside a sequence");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.rejected) |-> r_out.busy_res)
        else $error("reject reported while idle");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 1-Wire bus master. A driver process feeds one
// tick word per handshake from a queue filled by the stimulus process, and a
// bit-accurate engine predicts the result word of every accepted tick. A
// monitor compares each result word field by field with the oldest
// prediction. Stimulus covers read and write slots in both timing modes,
// reset/presence and byte touches in overdrive, commands given while busy,
// and random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import ow_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_OVERDRIVE = 3'd0;
    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int          LINE_RANDOM  = -1;

    typedef struct packed {
        t_req       req;
        logic [7:0] data;
        logic       line;
    } t_bus_tick;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_QUARTER,
        RX_RARE
    } t_rx_mode;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [7:0] send_data, [8] line_level, pad
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] req_type

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [0] drive_low, [1] busy_res, [2] done_res,
                                       // [10:3] read_data, [11] presence,
                                       // [12] rejected, pad

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    onewire_bus_master u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bus engine prediction: own copy of the sequencer state and the
    // overdrive register as written over the configuration port.
    // ------------------------------------------------------------------------
    logic            od_live       = 1'b0;
    t_phase          eng_phase     = PH_IDLE;
    logic [CntW-1:0] eng_count     = '0;
    logic [3:0]      bits_left     = '0;
    logic [7:0]      tx_shift      = '0;
    logic [7:0]      rx_shift      = '0;
    logic            presence_seen = 1'b0;
    logic            single_touch  = 1'b0;

    t_bus_tick  tick_queue[$];
    t_ow_result expected_results[$];
    int unsigned mismatches = 0;

    // Ticks spent in one phase for the live timing mode
    function automatic logic [CntW-1:0] slot_ticks(input t_phase ph, input logic b);
        case (ph)
            PH_RST_WAIT: return od_live ? 11'd10  : 11'd0;
            PH_RST_LOW:  return od_live ? 11'd280 : 11'd1920;
            PH_RST_REL:  return od_live ? 11'd34  : 11'd280;
            PH_RST_REC:  return od_live ? 11'd160 : 11'd1640;
            PH_SLOT_LOW: return b ? (od_live ? 11'd6 : 11'd24) : (od_live ? 11'd30 : 11'd240);
            PH_SLOT_REL: return b ? (od_live ? 11'd3 : 11'd36) : (od_live ? 11'd10 : 11'd40);
            PH_SLOT_REC: return od_live ? 11'd28 : 11'd220;
            default:     return 11'd1;
        endcase
    endfunction

    // Advance the engine by one tick and return the result word it yields
    function automatic t_ow_result advance_bus_engine(input t_req req, input logic [7:0] data,
                                                      input logic line);
        t_ow_result r;
        logic       b;
        logic       finished;
        logic       bit_end;
        r        = '0;
        finished = 1'b0;
        bit_end  = 1'b0;

        if (eng_phase != PH_IDLE) begin
            if (req != REQ_TICK) r.rejected = 1'b1;
        end else if (req != REQ_TICK) begin
            eng_count = '0;
            rx_shift  = '0;
            if (req == REQ_RESET) begin
                // standard timing has no wait before the reset pulse
                eng_phase    = (slot_ticks(PH_RST_WAIT, 1'b0) == '0) ? PH_RST_LOW : PH_RST_WAIT;
                bits_left    = '0;
                single_touch = 1'b0;
            end else begin
                eng_phase    = PH_SLOT_LOW;
                single_touch = (req == REQ_BIT);
                tx_shift     = single_touch ? {7'd0, data[0]} : data;
                bits_left    = single_touch ? 4'd1 : 4'd8;
            end
        end

        if (eng_phase != PH_IDLE) begin
            r.busy_res  = 1'b1;
            b           = tx_shift[0];
            r.drive_low = (eng_phase == PH_RST_LOW) || (eng_phase == PH_SLOT_LOW);
            // sample the line on the first tick of the recovery phases
            if (eng_count == '0) begin
                if (eng_phase == PH_RST_REC)       presence_seen = ~line;
                else if (eng_phase == PH_SLOT_REC) rx_shift = {line, rx_shift[7:1]};
            end
            eng_count = eng_count + 1'b1;
            if (eng_count >= slot_ticks(eng_phase, b)) begin
                eng_count = '0;
                case (eng_phase)
                    PH_RST_WAIT: eng_phase = PH_RST_LOW;
                    PH_RST_LOW:  eng_phase = PH_RST_REL;
                    PH_RST_REL:  eng_phase = PH_RST_REC;
                    PH_RST_REC:  finished  = 1'b1;
                    PH_SLOT_LOW: eng_phase = PH_SLOT_REL;
                    PH_SLOT_REL: begin
                        if (b) begin
                            eng_phase = PH_SLOT_REC;
                        end else begin
                            rx_shift = {1'b0, rx_shift[7:1]};
                            bit_end  = 1'b1;
                        end
                    end
                    default:     bit_end = 1'b1;
                endcase
                if (bit_end) begin
                    tx_shift = tx_shift >> 1;
                    if (bits_left <= 4'd1) begin
                        bits_left = '0;
                        finished  = 1'b1;
                    end else begin
                        bits_left = bits_left - 1'b1;
                        eng_phase = PH_SLOT_LOW;
                    end
                end
                if (finished) begin
                    r.done_res = 1'b1;
                    if (eng_phase == PH_RST_REC) r.read_data = 8'd0;
                    else r.read_data = single_touch ? {7'd0, rx_shift[7]} : rx_shift;
                    eng_phase = PH_IDLE;
                end
            end
        end
        r.presence = presence_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: predict on every accepted word, then offer the next one in
    // bursts separated by random gaps.
    // ------------------------------------------------------------------------
    t_bus_tick next_word;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(advance_bus_engine(t_req'(s_axis_tuser),
                                                              s_axis_tdata[7:0],
                                                              s_axis_tdata[8]));
            end
            // hold the current word until it is taken
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (tick_queue.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    next_word = tick_queue.pop_front();
                    s_axis_tuser  <= next_word.req;
                    s_axis_tdata  <= {7'd0, next_word.line, next_word.data};
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 3) == 0) begin
                        // long stretch with no sender idling
                        burst_left = $urandom_range(300, 1000);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on a changing pattern, plus a long hold on request.
    // ------------------------------------------------------------------------
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    int unsigned mode_left     = 0;
    int unsigned pattern_ctr   = 0;
    t_rx_mode    rx_mode       = RX_OPEN;

    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (mode_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        pattern_ctr++;
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:    m_axis_tready <= 1'b1;
                RX_COIN:    m_axis_tready <= $urandom_range(0, 1);
                RX_QUARTER: m_axis_tready <= (pattern_ctr % 4 == 0);
                default:    m_axis_tready <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    t_ow_result got_word;
    t_ow_result want_word;

    task automatic report_field(input string nm, input int unsigned exp_v,
                                input int unsigned act_v);
        if (exp_v != act_v) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, nm, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_word = t_ow_result'(m_axis_tdata[ResW-1:0]);
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: result word expected none actual %h", $time, m_axis_tdata);
            end else begin
                want_word = expected_results.pop_front();
                report_field("drive_low", want_word.drive_low, got_word.drive_low);
                report_field("busy_res",  want_word.busy_res,  got_word.busy_res);
                report_field("done_res",  want_word.done_res,  got_word.done_res);
                report_field("read_data", want_word.read_data, got_word.read_data);
                report_field("presence",  want_word.presence,  got_word.presence);
                report_field("rejected",  want_word.rejected,  got_word.rejected);
            end
        end
    end

    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("onewire_bus_master: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_OVERDRIVE) od_live = val[0];
    endtask

    task automatic queue_word(input t_req req, input logic [7:0] data, input logic line);
        t_bus_tick w;
        w.req  = req;
        w.data = data;
        w.line = line;
        tick_queue.push_back(w);
    endtask

    // Plain ticks with random data; line fixed or random
    task automatic queue_ticks(input int n, input int lvl);
        for (int i = 0; i < n; i++) begin
            queue_word(REQ_TICK, 8'($urandom_range(0, 255)),
                       (lvl == LINE_RANDOM) ? 1'($urandom_range(0, 1)) : 1'(lvl));
        end
    endtask

    // Sample off the falling edge so the clocked processes have settled
    task automatic wait_drain();
        do @(negedge i_clk);
        while (tick_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    endtask

    // Drain, then clock out whatever sequence is still running
    task automatic settle();
        wait_drain();
        while (eng_phase != PH_IDLE) begin
            queue_ticks(64, LINE_RANDOM);
            wait_drain();
        end
    endtask

    // Worst-case length of one sequence, command tick included
    function automatic int longest_span(input t_req req, input logic od);
        case (req)
            REQ_RESET: return od ? 484 : 3840;
            REQ_BIT:   return od ? 40 : 280;
            default:   return od ? 320 : 2240;
        endcase
    endfunction

    // Well-formed command streams, with a share of commands sent while busy
    task automatic queue_random(input int n_cmds);
        t_req req;
        int   pick;
        int   span;
        int   gap;
        for (int i = 0; i < n_cmds; i++) begin
            pick = $urandom_range(0, 9);
            req  = (pick < 2) ? REQ_RESET : (pick < 5) ? REQ_BYTE : REQ_BIT;
            queue_word(req, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            span = longest_span(req, od_live);
            if ($urandom_range(0, 9) == 0) gap = $urandom_range(0, span - 1);
            else gap = span - 1 + $urandom_range(0, 6);
            queue_ticks(gap, LINE_RANDOM);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apb_write(REG_OVERDRIVE, 32'd0);

        // Standard timing: idle tick, read slot on a high line, busy reject,
        // then a write slot that reads zero
        queue_word(REQ_TICK, 8'hFF, 1'b1);
        queue_word(REQ_BIT, 8'hFF, 1'b1);
        queue_word(REQ_BYTE, 8'hFF, 1'b0);
        queue_ticks(285, 1);
        queue_word(REQ_BIT, 8'hFE, 1'b0);
        queue_ticks(285, LINE_RANDOM);
        settle();

        apb_write(REG_OVERDRIVE, 32'd1);

        // Overdrive: reset with a device answering
        queue_word(REQ_RESET, 8'h00, 1'b0);
        queue_ticks(490, 0);
        queue_word(REQ_BYTE, 8'hA5, 1'b0);
        queue_word(REQ_BIT, 8'h01, 1'b1);
        queue_ticks(330, LINE_RANDOM);
        // reject on the done tick, then start on the very next tick
        queue_word(REQ_BIT, 8'h00, 1'b0);
        queue_ticks(38, LINE_RANDOM);
        queue_word(REQ_RESET, 8'h00, 1'b0);
        queue_word(REQ_BIT, 8'h01, 1'b0);
        queue_ticks(50, LINE_RANDOM);
        // stall the receiver long enough to back up the input
        hold_requests++;
        settle();

        queue_random(1);
        wait_drain();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("onewire_bus_master: match");
        end else begin
            $display("onewire_bus_master: mismatch");
        end
        $finish;
    end

endmodule
